FILE: rtl/sjis_euc_glyph_locator_core_defines.svh
// Assertion macros used by the checker file of the glyph locator.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SJIS_EUC_GLYPH_LOCATOR_CORE_DEFINES_SVH
`define SJIS_EUC_GLYPH_LOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEGL_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glyph locator check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEGL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glyph locator check failed");

`endif

FILE: rtl/segl_pkg.sv
`default_nettype none

package segl_pkg;

	localparam int unsigned OFFSET_W = 20;

	// Text decoding modes, as written to the mode register.
	typedef enum logic [1:0] {
		MODE_ROM  = 2'd0,
		MODE_SJIS = 2'd1,
		MODE_EUC  = 2'd2
	} mode_t;

	// One queued result: a single glyph, or the pair of halves of a double-width glyph.
	typedef struct packed {
		logic                       font_select;
		logic                       pair;
		logic signed [OFFSET_W-1:0] offset;
	} res_t;

	// What the decoder makes of one byte.
	typedef struct packed {
		logic emit;
		logic lead_load;
		logic lead_clear;
		res_t res;
	} dec_t;

endpackage

`default_nettype wire

FILE: rtl/segl_decode.sv
`default_nettype none

module segl_decode (
	input  wire logic [7:0]       code_byte,
	input  wire segl_pkg::mode_t  text_mode,
	input  wire logic [7:0]       lead_byte,
	output segl_pkg::dec_t        dec
);

	function automatic logic signed [19:0] sjis_off(input logic [7:0] lead,
		input logic [7:0] trail);
		logic signed [19:0] l;
		logic signed [19:0] t;
		logic signed [19:0] row;
		logic signed [19:0] col;
		l = signed'({12'd0, lead});
		t = signed'({12'd0, trail});
		if (lead >= 8'h81 && lead <= 8'h9f) begin
			row = (l - 20'sd129) * 20'sd2;
		end else begin
			row = (l - 20'sd224) * 20'sd2 + 20'sd62;
		end
		if (trail >= 8'h40 && trail <= 8'h7e) begin
			col = t - 20'sd64;
		end else if (trail >= 8'h80 && trail <= 8'h9e) begin
			col = t - 20'sd128 + 20'sd63;
		end else begin
			col = t - 20'sd159;
			row = row + 20'sd1;
		end
		return 20'sd4096 + (row * 20'sd94 + col) * 20'sd32;
	endfunction

	function automatic logic signed [19:0] euc_off(input logic [7:0] lead,
		input logic [7:0] trail);
		logic signed [19:0] l;
		logic signed [19:0] t;
		l = signed'({12'd0, lead});
		t = signed'({12'd0, trail});
		return 20'sd4096 + ((l - 20'sd161) * 20'sd94 + (t - 20'sd161)) * 20'sd32;
	endfunction

	logic is_lead;
	logic signed [19:0] single_off;

	assign single_off = signed'({8'd0, code_byte, 4'd0});

	always_comb begin
		dec     = '0;
		is_lead = 1'b0;
		if (code_byte != 8'd0) begin
			case (text_mode)
				segl_pkg::MODE_ROM: begin
					dec.emit       = 1'b1;
					dec.res.offset = single_off;
				end
				segl_pkg::MODE_SJIS, segl_pkg::MODE_EUC: begin
					if (lead_byte == 8'd0) begin
						if (text_mode == segl_pkg::MODE_SJIS) begin
							is_lead = (code_byte >= 8'h81 && code_byte <= 8'h9f) ||
								(code_byte >= 8'he0 && code_byte <= 8'hfc);
						end else begin
							is_lead = (code_byte >= 8'h81 && code_byte <= 8'hfe);
						end
						if (is_lead) begin
							dec.lead_load = 1'b1;
						end else begin
							dec.emit            = 1'b1;
							dec.res.font_select = 1'b1;
							dec.res.offset      = single_off;
						end
					end else begin
						dec.emit            = 1'b1;
						dec.lead_clear      = 1'b1;
						dec.res.font_select = 1'b1;
						dec.res.pair        = 1'b1;
						if (text_mode == segl_pkg::MODE_SJIS) begin
							dec.res.offset = sjis_off(lead_byte, code_byte);
						end else begin
							dec.res.offset = euc_off(lead_byte, code_byte);
						end
					end
				end
				default: begin
					dec = '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/segl_outq.sv
`default_nettype none

module segl_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire segl_pkg::res_t      push_res,
	output logic                     room,
	output logic                     glyph_valid,
	input  wire logic                glyph_stall,
	output logic                     font_select,
	output logic signed [19:0]       glyph_offset,
	output logic                     cell_back,
	output logic                     last
);

	segl_pkg::res_t ent_q [2];
	logic [1:0]     count_q;
	logic           head_q;
	logic           tail_q;
	logic           half_q;
	logic           fire;
	logic           pop;
	segl_pkg::res_t head_res;

	assign head_res     = ent_q[head_q];
	assign room         = (count_q != 2'd2);
	assign glyph_valid  = (count_q != 2'd0);
	assign font_select  = head_res.font_select;
	// Pair offsets have their low five bits clear, so the right half just sets bit 4.
	assign glyph_offset = head_res.pair ?
		{head_res.offset[19:5], half_q, head_res.offset[3:0]} : head_res.offset;
	assign cell_back    = head_res.pair && !half_q;
	assign last         = !head_res.pair || half_q;
	assign fire         = glyph_valid && !glyph_stall;
	assign pop          = fire && last;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[tail_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			head_q  <= 1'b0;
			tail_q  <= 1'b0;
			half_q  <= 1'b0;
		end else begin
			if (push) begin
				tail_q <= ~tail_q;
			end
			if (pop) begin
				head_q <= ~head_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
			if (fire) begin
				half_q <= !last;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sjis_euc_glyph_locator_core.sv
`default_nettype none

// Channel   | Direction | Handshake                 | Word
// ----------+-----------+---------------------------+--------------------------------------
// code      | in        | code_valid / code_stall   | code_byte
// glyph     | out       | glyph_valid / glyph_stall | font_select, glyph_offset, cell_back,
//           |           |                           | last
// cfg       | in        | cfg_wen                   | cfg_wdata (text mode)
//
// A byte is taken into the input register and decoded there; a result is then pushed into
// the result queue, whose head word goes out on the glyph channel. A byte is accepted
// every cycle unless the input register waits for queue room; a double-width glyph goes
// out as two words, which sets the long-run rate on Japanese text. Reset clears the mode,
// the pending lead byte and all valid state. A stall on the glyph side fills the two-entry
// result queue and then holds the input register, which raises code_stall.
module sjis_euc_glyph_locator_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [1:0]        cfg_wdata,
	input  wire logic              code_valid,
	output logic                   code_stall,
	input  wire logic [7:0]        code_byte,
	output logic                   glyph_valid,
	input  wire logic              glyph_stall,
	output logic                   font_select,
	output logic signed [19:0]     glyph_offset,
	output logic                   cell_back,
	output logic                   last
);

	segl_pkg::mode_t text_mode_q;
	logic [7:0]      lead_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	segl_pkg::dec_t  dec;
	logic            room;
	logic            advance;

	// The user must change the mode register only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_mode_q <= segl_pkg::MODE_ROM;
		end else if (cfg_wen) begin
			text_mode_q <= segl_pkg::mode_t'(cfg_wdata);
		end
	end

	// Input register. It drains once its byte is decoded and the result queue has room for any result.
	assign advance    = valid_s1 && (!dec.emit || room);
	assign code_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!code_stall) begin
			valid_s1 <= code_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_valid && !code_stall) begin
			byte_s1 <= code_byte;
		end
	end

	segl_decode u_decode (
		.code_byte (byte_s1),
		.text_mode (text_mode_q),
		.lead_byte (lead_q),
		.dec       (dec)
	);

	// The pending lead byte is updated only when its byte leaves the input register,
	// so it always reflects the bytes decoded so far and none ahead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 8'd0;
		end else if (advance) begin
			if (dec.lead_load) begin
				lead_q <= byte_s1;
			end else if (dec.lead_clear) begin
				lead_q <= 8'd0;
			end
		end
	end

	// Result queue: one entry per byte that gives a result, a pair entry being sent as two words.
	segl_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (advance && dec.emit),
		.push_res     (dec.res),
		.room         (room),
		.glyph_valid  (glyph_valid),
		.glyph_stall  (glyph_stall),
		.font_select  (font_select),
		.glyph_offset (glyph_offset),
		.cell_back    (cell_back),
		.last         (last)
	);

endmodule

`default_nettype wire

FILE: rtl/segl_checker.sv
`default_nettype none

`include "sjis_euc_glyph_locator_core_defines.svh"

module segl_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              glyph_valid,
	input wire logic              glyph_stall,
	input wire logic              font_select,
	input wire logic signed [19:0] glyph_offset,
	input wire logic              cell_back,
	input wire logic              last
);

	// The right half follows its left half at once, sixteen bytes further on.
	`SEGL_ASSERT_NEXT(a_right_follows_left, glyph_valid && !glyph_stall && cell_back, glyph_valid && !cell_back && last && font_select && (glyph_offset == $past(glyph_offset) + 20'sd16))

	// A left half is never final, comes from the loaded font and sits on a 32-byte boundary.
	`SEGL_ASSERT_SAME(a_left_half_shape, glyph_valid && cell_back, !last && font_select && (glyph_offset[4:0] == 5'd0))

	// The built-in font only ever gives single glyphs.
	`SEGL_ASSERT_SAME(a_rom_single, glyph_valid && !font_select, last && !cell_back)

	// A stalled word holds.
	`SEGL_ASSERT_NEXT(a_stall_holds, glyph_valid && glyph_stall, glyph_valid && $stable(glyph_offset) && $stable(cell_back) && $stable(last))

endmodule

bind sjis_euc_glyph_locator_core segl_checker u_segl_checker (.*);

`default_nettype wire

FILE: dv/glyph_stream_checker.sv
`default_nettype none

module glyph_stream_checker
	import segl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [1:0]        cfg_wdata,
	input  wire logic              code_valid,
	input  wire logic              code_stall,
	input  wire logic [7:0]        code_byte,
	input  wire logic              glyph_valid,
	input  wire logic              glyph_stall,
	input  wire logic              font_select,
	input  wire logic signed [19:0] glyph_offset,
	input  wire logic              cell_back,
	input  wire logic              last,
	output int unsigned            glyphs_owed,
	output int unsigned            faults
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KANJI_BASE = 4096;
	localparam int ROW_CELLS  = 94;

	typedef struct packed {
		logic                       font_select;
		logic signed [OFFSET_W-1:0] offset;
		logic                       cell_back;
		logic                       last;
	} glyph_t;

	glyph_t      owed_q[$];
	logic [1:0]  text_mode;
	logic [7:0]  held_lead;
	int unsigned fault_count = 0;

	function automatic glyph_t make_glyph(logic sel, int offs, logic back, logic fin);
		glyph_t g;
		g.font_select = sel;
		g.offset      = offs[OFFSET_W-1:0];
		g.cell_back   = back;
		g.last        = fin;
		return g;
	endfunction

	// Offset of the left half of a double-width glyph; no range checks, as in the block.
	function automatic int kanji_offset(logic [7:0] lead, logic [7:0] trail, logic is_sjis);
		int ld;
		int tr;
		int row;
		int col;
		ld = lead;
		tr = trail;
		if (!is_sjis)
			return KANJI_BASE + ((ld - 'ha1) * ROW_CELLS + (tr - 'ha1)) * 32;
		if (ld >= 'h81 && ld <= 'h9f)
			row = (ld - 'h81) * 2;
		else
			row = (ld - 'he0) * 2 + 62;
		if (tr >= 'h40 && tr <= 'h7e) begin
			col = tr - 'h40;
		end else if (tr >= 'h80 && tr <= 'h9e) begin
			col = tr - 'h80 + 63;
		end else begin
			col = tr - 'h9f;
			row = row + 1;
		end
		return KANJI_BASE + (row * ROW_CELLS + col) * 32;
	endfunction

	function automatic void locate_glyphs(logic [7:0] b);
		logic is_lead;
		int   offs;
		if (b == 8'h00)
			return;
		case (text_mode)
			MODE_ROM: owed_q.push_back(make_glyph(1'b0, int'(b) * 16, 1'b0, 1'b1));
			MODE_SJIS, MODE_EUC: begin
				if (held_lead == 8'h00) begin
					if (text_mode == MODE_SJIS)
						is_lead = (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
					else
						is_lead = (b >= 8'h81 && b <= 8'hfe);
					if (is_lead)
						held_lead = b;
					else
						owed_q.push_back(make_glyph(1'b1, int'(b) * 16, 1'b0, 1'b1));
				end else begin
					offs      = kanji_offset(held_lead, b, text_mode == MODE_SJIS);
					held_lead = 8'h00;
					owed_q.push_back(make_glyph(1'b1, offs, 1'b1, 1'b0));
					owed_q.push_back(make_glyph(1'b1, offs + 16, 1'b0, 1'b1));
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void note_fault(string what, glyph_t want, glyph_t got);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t %s: expected sel=%0b off=%0d back=%0b last=%0b, got sel=%0b off=%0d back=%0b last=%0b",
				$time, what, want.font_select, want.offset, want.cell_back, want.last,
				got.font_select, got.offset, got.cell_back, got.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		glyph_t want;
		glyph_t got;
		if (!arst_n) begin
			text_mode = MODE_ROM;
			held_lead = 8'h00;
			owed_q.delete();
		end else begin
			// A result word can never belong to a byte taken at the same edge, so the
			// comparison comes before the new prediction.
			if (glyph_valid && !glyph_stall) begin
				got = make_glyph(font_select, int'(glyph_offset), cell_back, last);
				if (owed_q.size() == 0) begin
					note_fault("unexpected glyph word", got, got);
				end else begin
					want = owed_q.pop_front();
					if (got.font_select !== want.font_select || got.offset !== want.offset ||
					    got.cell_back !== want.cell_back || got.last !== want.last)
						note_fault("glyph word mismatch", want, got);
				end
			end
			if (cfg_wen)
				text_mode = cfg_wdata;
			if (code_valid && !code_stall)
				locate_glyphs(code_byte);
		end
		glyphs_owed <= owed_q.size();
		faults      <= fault_count;
	end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

// Stimulus and verdict for the glyph locator. The checker beside the block watches both
// channels and the mode register, predicts every glyph word and keeps the fault count;
// this module only feeds bytes and modes, applies back-pressure and decides the outcome.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import segl_pkg::*;

	// The fourth mode code has no meaning; the block must produce nothing in it.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned TEXT_BYTES = 850;

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [1:0]         cfg_wdata;
	logic               code_valid;
	logic               code_stall;
	logic [7:0]         code_byte;
	logic               glyph_valid;
	logic               glyph_stall;
	logic               font_select;
	logic signed [19:0] glyph_offset;
	logic               cell_back;
	logic               last;
	int unsigned        glyphs_owed;
	int unsigned        faults;

	// Mode as last written, and the number of bytes sent that the block acts upon.
	logic [1:0]         mode_now;
	int unsigned        bytes_sent;
	logic               steady;

	sjis_euc_glyph_locator_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.code_byte    (code_byte),
		.glyph_valid  (glyph_valid),
		.glyph_stall  (glyph_stall),
		.font_select  (font_select),
		.glyph_offset (glyph_offset),
		.cell_back    (cell_back),
		.last         (last)
	);

	glyph_stream_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.code_byte    (code_byte),
		.glyph_valid  (glyph_valid),
		.glyph_stall  (glyph_stall),
		.font_select  (font_select),
		.glyph_offset (glyph_offset),
		.cell_back    (cell_back),
		.last         (last),
		.glyphs_owed  (glyphs_owed),
		.faults       (faults)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Most gaps between bytes are short; now and then the sender goes quiet for a while.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offers one byte and returns in the time step of the edge that accepts it. The valid
	// stays high on return, so a following byte with no gap goes out back to back.
	task automatic send_byte(logic [7:0] b);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			code_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		code_valid <= 1'b1;
		code_byte  <= b;
		@(posedge clk);
		while (code_stall)
			@(posedge clk);
		if (mode_now != MODE_UNUSED && b != 8'h00)
			bytes_sent++;
	endtask

	// Holds the sender until every predicted word has come out, then lets the clock run on
	// in case the last byte was a lead or a zero that is still in flight.
	task automatic drain();
		code_valid <= 1'b0;
		@(posedge clk);
		while (glyphs_owed != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_mode(logic [1:0] m);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		mode_now = m;
	endtask

	function automatic logic [7:0] pick_lead();
		if (mode_now == MODE_SJIS)
			return $urandom_range(0, 1) ? 8'($urandom_range('h81, 'h9f))
			                            : 8'($urandom_range('he0, 'hfc));
		// EUC leads are mostly in the kanji rows, sometimes in the odd range below them.
		return $urandom_range(0, 4) != 0 ? 8'($urandom_range('ha1, 'hfe))
		                                 : 8'($urandom_range('h81, 'ha0));
	endfunction

	function automatic logic [7:0] pick_trail();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 8'($urandom_range(1, 255));
		if (mode_now == MODE_EUC)
			return 8'($urandom_range('ha1, 'hfe));
		// Shift-JIS trail bytes fall into three bands, the last of which bumps the row.
		case (roll % 3)
			0:       return 8'($urandom_range('h40, 'h7e));
			1:       return 8'($urandom_range('h80, 'h9e));
			default: return 8'($urandom_range('h9f, 'hfc));
		endcase
	endfunction

	// One piece of text: mostly a well-formed double-byte character with random content,
	// sometimes a plain single byte, and some noise that can break a pair apart.
	task automatic send_text_unit();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (mode_now == MODE_ROM || roll >= 85) begin
			send_byte(8'($urandom_range(0, 255)));
		end else if (roll >= 65) begin
			send_byte(8'($urandom_range(1, 'h7f)));
		end else begin
			send_byte(pick_lead());
			send_byte(pick_trail());
		end
	endtask

	// Back-pressure on the glyph side: long free-running stretches, short stalls and the
	// occasional long one that fills the result queue and pushes back on the code side.
	initial begin : glyph_back_pressure
		int unsigned flow;
		int unsigned hold;
		glyph_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			flow = $urandom_range(0, 7) == 0 ? $urandom_range(60, 200) : $urandom_range(1, 10);
			hold = $urandom_range(0, 9) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 3);
			repeat (flow) @(posedge clk);
			glyph_stall <= 1'b1;
			repeat (hold) @(posedge clk);
			glyph_stall <= 1'b0;
		end
	end

	initial begin : text_stimulus
		int unsigned units;
		int unsigned pick;
		arst_n     = 1'b0;
		cfg_wen    = 1'b0;
		cfg_wdata  = MODE_ROM;
		code_valid = 1'b0;
		code_byte  = 8'h00;
		mode_now   = MODE_ROM;
		bytes_sent = 0;
		steady     = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Built-in font straight after reset, including the terminator and a byte that
		// would be a lead in the other modes.
		send_byte(8'h01);
		send_byte(8'hff);
		send_byte(8'h00);
		send_byte(8'h81);

		// Shift-JIS: a single byte, the corners of the lead and trail ranges, and a
		// terminator between a lead and its trail byte, which must leave the lead held.
		set_mode(MODE_SJIS);
		send_byte(8'h41);
		send_byte(8'h81);
		send_byte(8'h40);
		send_byte(8'h9f);
		send_byte(8'h7e);
		send_byte(8'hfc);
		send_byte(8'hfc);
		send_byte(8'h85);
		send_byte(8'h00);
		send_byte(8'h9f);

		// A Shift-JIS lead held across a switch to EUC is decoded with the EUC rule.
		send_byte(8'h88);
		set_mode(MODE_EUC);
		send_byte(8'ha1);

		// EUC: lowest and highest kanji, then a pair well outside the table, which
		// gives a negative offset.
		send_byte(8'ha1);
		send_byte(8'ha1);
		send_byte(8'hfe);
		send_byte(8'hfe);
		send_byte(8'h81);
		send_byte(8'h01);

		// In the built-in font mode a held lead is ignored but kept for later.
		send_byte(8'hb0);
		set_mode(MODE_ROM);
		send_byte(8'h41);
		set_mode(MODE_EUC);
		send_byte(8'hc0);

		// The unused mode code must produce nothing at all.
		set_mode(MODE_UNUSED);
		send_byte(8'h41);
		send_byte(8'h00);

		// Random text in phases, each under a fresh mode. Every mode change waits for the
		// block to empty, which also gives the sender a full pause now and then.
		while (bytes_sent < TEXT_BYTES) begin
			pick = $urandom_range(0, 4);
			set_mode(pick == 0 ? MODE_ROM : (pick <= 2 ? MODE_SJIS : MODE_EUC));
			units = $urandom_range(40, 120);
			for (int unsigned i = 0; i < units; i++) begin
				if (i % 30 == 0)
					steady = $urandom_range(0, 3) == 0;
				send_text_unit();
			end
			steady = 1'b0;
		end

		drain();
		repeat (10) @(posedge clk);
		if (faults == 0)
			$display("** sjis_euc_glyph_locator_core: PASSED **");
		else
			$display("** sjis_euc_glyph_locator_core: FAILED **");
		$finish;
	end

	// Far beyond the slowest correct run, even with every stall at its longest.
	initial begin : watchdog
		#6_000_000;
		$display("** sjis_euc_glyph_locator_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
